### hw/rtl/mfpe_pkg.sv
// Package with the shared types and constants of the marker frame payload extractor.
`default_nettype none

package mfpe_pkg;

    // Start marker and footer bytes.
    localparam logic [7:0] MARK_FIRST  = 8'hAB;
    localparam logic [7:0] MARK_SECOND = 8'hBA;
    localparam logic [7:0] FOOT_FIRST  = 8'hEB;
    localparam logic [7:0] FOOT_SECOND = 8'hBE;

    // The tail window holds the last eight bytes; payload leaves it as it falls out.
    localparam int WIN_DEPTH  = 8;
    // Payload starts after the two marker bytes; emission begins once the window is full of it.
    localparam int EMIT_START = WIN_DEPTH + 1;
    // A frame must be longer than the offset plus marker and footer.
    localparam int LEN_MARGIN = WIN_DEPTH + 2;

    localparam int OFFSET_W = 11;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 11'd14;

    // Result queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_verdict;
        logic       frame_ok;
    } res_t;

    // Queue status as seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

### hw/rtl/mfpe_front.sv
// Front part: byte position, marker check, tail window and result classification.
`default_nettype none

module mfpe_front #(
    parameter int MAX_PACKET_LEN = 65535
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [7:0]                    in_byte,
    input  wire logic                          end_of_packet,
    input  wire logic                          cfg_write,
    input  wire logic [mfpe_pkg::OFFSET_W-1:0] cfg_data,
    output logic                               push,
    output mfpe_pkg::res_t                     push_item
);

    localparam int POS_W = $clog2(MAX_PACKET_LEN + 1);
    localparam int CMP_W = (POS_W + 1 > mfpe_pkg::OFFSET_W + 1) ?
                           POS_W + 1 : mfpe_pkg::OFFSET_W + 1;
    localparam int WD    = mfpe_pkg::WIN_DEPTH;

    logic [mfpe_pkg::OFFSET_W-1:0] offset_reg;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          first_ok_reg, first_ok_next;
    logic                          marker_ok_reg, marker_ok_next;
    logic [7:0]                    win_reg [WD];

    logic [CMP_W-1:0] idx_w, off_w, len_w;
    logic             footer_ok;
    logic             frame_ok;
    logic             emit_payload;

    always_comb
    begin
        idx_w = CMP_W'(pos_reg);
        off_w = CMP_W'(offset_reg);
        len_w = (pos_reg == POS_W'(MAX_PACKET_LEN)) ? CMP_W'(MAX_PACKET_LEN) : idx_w + 1'b1;

        first_ok_next  = first_ok_reg;
        marker_ok_next = marker_ok_reg;
        if (idx_w == off_w)
        begin
            first_ok_next = (in_byte == mfpe_pkg::MARK_FIRST);
        end
        else if (idx_w == off_w + 1'b1)
        begin
            marker_ok_next = first_ok_reg && (in_byte == mfpe_pkg::MARK_SECOND);
        end

        // Window after the shift is win_reg[1..7] followed by the new byte.
        footer_ok = (win_reg[1] == mfpe_pkg::FOOT_FIRST) &&
                    (win_reg[2] == mfpe_pkg::FOOT_SECOND) &&
                    (win_reg[3] == 8'h00) && (win_reg[4] == 8'h00) &&
                    (win_reg[5] == 8'h00) && (win_reg[6] == 8'h00) &&
                    (win_reg[7] == 8'h00) && (in_byte == 8'h00);

        frame_ok = (len_w > off_w + CMP_W'(mfpe_pkg::LEN_MARGIN)) &&
                   marker_ok_next && footer_ok;

        emit_payload = marker_ok_next && (idx_w >= off_w + CMP_W'(mfpe_pkg::EMIT_START));

        pos_next = pos_reg;
        if (end_of_packet)
        begin
            pos_next       = '0;
            first_ok_next  = 1'b0;
            marker_ok_next = 1'b0;
        end
        else if (pos_reg != POS_W'(MAX_PACKET_LEN))
        begin
            pos_next = pos_reg + 1'b1;
        end

        push = accept && (end_of_packet || emit_payload);
        push_item.out_byte   = end_of_packet ? 8'h00 : win_reg[1];
        push_item.is_verdict = end_of_packet;
        push_item.frame_ok   = end_of_packet && frame_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= mfpe_pkg::OFFSET_RESET;
            pos_reg       <= '0;
            first_ok_reg  <= 1'b0;
            marker_ok_reg <= 1'b0;
            for (int k = 0; k < WD; k++)
            begin
                win_reg[k] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                offset_reg <= cfg_data;
            end
            if (accept)
            begin
                pos_reg       <= pos_next;
                first_ok_reg  <= first_ok_next;
                marker_ok_reg <= marker_ok_next;
                for (int k = 0; k < WD - 1; k++)
                begin
                    win_reg[k] <= win_reg[k+1];
                end
                win_reg[WD-1] <= in_byte;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mfpe_queue.sv
// Short result queue between the front and back parts.
`default_nettype none

module mfpe_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire mfpe_pkg::res_t push_item,
    input  wire logic       pop,
    output mfpe_pkg::res_t  head_item,
    output mfpe_pkg::q_stat_t stat
);

    mfpe_pkg::res_t                 mem [mfpe_pkg::Q_DEPTH];
    logic [mfpe_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [mfpe_pkg::Q_CNT_W-1:0]   count_reg;

    assign stat.full  = (count_reg == mfpe_pkg::Q_CNT_W'(mfpe_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mfpe_back.sv
// Back part: output register that presents queued results on the master stream.
`default_nettype none

module mfpe_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mfpe_pkg::q_stat_t stat,
    input  wire mfpe_pkg::res_t    head_item,
    output logic              pop,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic [1:0]        m_axis_tuser
);

    logic           valid_reg;
    mfpe_pkg::res_t item_reg;

    // Refill whenever the register is empty or its word is taken in this cycle.
    assign pop = !stat.empty && (!valid_reg || m_axis_tready);

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = item_reg.out_byte;
    assign m_axis_tuser  = {item_reg.frame_ok, item_reg.is_verdict};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/marker_frame_payload_extractor.sv
// Top level of the marker frame payload extractor.
//
// Packet bytes enter on the slave stream, one word per byte, with tlast on
// the final byte of each packet. Bytes before the configured offset are
// skipped, the two bytes at the offset must read AB BA, and the last eight
// bytes must read EB BE followed by six zero bytes.
// Payload bytes leave on the master stream seven bytes behind the input, with
// tuser bit 0 low. The final byte of a packet produces a verdict word instead
// (tuser bit 0 high, tdata zero); tuser bit 1 then says whether downstream
// should keep the payload it has been given (1) or discard it (0).
// The offset register is written through the cfg channel, which is always
// ready; it should only be changed while no packet is in flight.
// Throughput is one byte per cycle while the result queue has room. A result word is
// written into the queue at the edge that accepts its byte and moves into the
// output register, which drives the master side, once that register is free.
// When the receiver stalls, results collect in a four-word queue; the slave
// side drops tready only once that queue is full, and resumes as it drains.
// Reset clears the byte position, marker flags, tail window and queue, and
// returns the offset to 14.
`default_nettype none

module marker_frame_payload_extractor #(
    parameter int MAX_PACKET_LEN = 65535
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Slave stream: tdata = in_byte[7:0]; tlast = end_of_packet.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // Master stream: tdata = out_byte[7:0]; tuser = is_verdict[0], frame_ok[1].
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,
    output logic [1:0]       m_axis_tuser,
    // Configuration: cfg_data = marker_offset[10:0].
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    logic              accept;
    logic              push;
    logic              pop;
    mfpe_pkg::res_t    push_item;
    mfpe_pkg::res_t    head_item;
    mfpe_pkg::q_stat_t q_stat;

    // Input is held off only while the result queue has no room left.
    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    mfpe_front #(
        .MAX_PACKET_LEN (MAX_PACKET_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (s_axis_tdata),
        .end_of_packet (s_axis_tlast),
        .cfg_write     (cfg_valid),
        .cfg_data      (cfg_data),
        .push          (push),
        .push_item     (push_item)
    );

    mfpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    mfpe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .stat          (q_stat),
        .head_item     (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

### sim/mfpe_checker.sv
// Checker that predicts the extractor's output words and compares them with the master stream.
`timescale 1ns / 1ps

module mfpe_checker
    import mfpe_pkg::*;
#(
    parameter int MAX_PACKET_LEN = 65535
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [10:0] cfg_data,
    output int               fail_count,
    output int               words_owed
);

    logic [OFFSET_W-1:0] offset;
    logic [15:0]         byte_pos;
    bit                  first_seen;
    bit                  marker_seen;
    logic [7:0]          tail [WIN_DEPTH];
    res_t                owed_q [$];
    res_t                due_word;
    bit                  word_made;
    int                  fails;

    // Advances the packet state by one byte and works out the word it causes, if any.
    function automatic void extract_byte(input logic [7:0] b, input bit last,
                                         output bit made, output res_t word);
        int idx;
        int off;
        int len;
        bit accept;
        idx  = byte_pos;
        off  = offset;
        made = 1'b0;
        word = '0;
        if (idx == off)
            first_seen = (b == MARK_FIRST);
        else if (idx == off + 1)
            marker_seen = first_seen && (b == MARK_SECOND);
        for (int k = 0; k < WIN_DEPTH - 1; k++)
            tail[k] = tail[k + 1];
        tail[WIN_DEPTH - 1] = b;
        if (last)
        begin
            len = (idx + 1 > MAX_PACKET_LEN) ? MAX_PACKET_LEN : idx + 1;
            accept = (len > off + LEN_MARGIN) && marker_seen
                     && tail[0] == FOOT_FIRST && tail[1] == FOOT_SECOND;
            for (int k = 2; k < WIN_DEPTH; k++)
                if (tail[k] != 8'h00)
                    accept = 1'b0;
            byte_pos        = '0;
            first_seen      = 1'b0;
            marker_seen     = 1'b0;
            made            = 1'b1;
            word.is_verdict = 1'b1;
            word.frame_ok   = accept;
        end
        else
        begin
            if (idx < MAX_PACKET_LEN)
                byte_pos = 16'(idx + 1);
            if (marker_seen && idx >= off + EMIT_START)
            begin
                made          = 1'b1;
                word.out_byte = tail[0];
            end
        end
    endfunction

    function automatic void check_field(input string name, input int due, input int seen);
        if (due != seen)
        begin
            fails++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, due, seen);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset      = OFFSET_RESET;
            byte_pos    = '0;
            first_seen  = 1'b0;
            marker_seen = 1'b0;
            for (int k = 0; k < WIN_DEPTH; k++)
                tail[k] = 8'h00;
            owed_q.delete();
            fails       = 0;
            fail_count <= 0;
            words_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                offset = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                extract_byte(s_axis_tdata, s_axis_tlast, word_made, due_word);
                if (word_made)
                    owed_q = {owed_q, due_word};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_q.size() == 0)
                begin
                    fails++;
                    $error("word: expected none, actual data 0x%0h user 0x%0h",
                           m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    due_word = owed_q.pop_front();
                    check_field("out_byte", due_word.out_byte, m_axis_tdata);
                    check_field("is_verdict", due_word.is_verdict, m_axis_tuser[0]);
                    check_field("frame_ok", due_word.frame_ok, m_axis_tuser[1]);
                end
            end
            fail_count <= fails;
            words_owed <= owed_q.size();
        end
    end

endmodule

### sim/tb_marker_frame_payload_extractor.sv
// Top level of the extractor testbench: clock, reset, packet stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_marker_frame_payload_extractor;
    import mfpe_pkg::*;

    localparam int MAX_LEN       = 65535;
    // Cycles the receiver holds off in one go, well past what the result queue can absorb.
    localparam int HOLD_CYCLES   = 80;
    // Margin after the last owed word.
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 8;
    localparam int PHASE_BYTES   = 155;

    // Ways in which a generated packet departs from a well-formed frame.
    typedef enum int {
        FLAW_NONE,
        FLAW_MARK1,
        FLAW_MARK2,
        FLAW_FOOTER,
        FLAW_NOISE
    } flaw_e;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // in_byte[7:0]
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // out_byte[7:0]
    logic [1:0]  m_axis_tuser;            // is_verdict[0], frame_ok[1]
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data      = '0;      // marker_offset[10:0]

    int fail_count;
    int words_owed;

    // Idling percentages for the sender and the receiver, changed between phases.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // One long receiver hold-off, requested by the stimulus and timed by the receiver.
    bit hold_go      = 1'b0;
    bit hold_used    = 1'b0;
    int hold_left    = 0;
    int bytes_sent   = 0;
    int cur_off      = OFFSET_RESET;

    int phase_off [PHASES] = '{14, 0, 1, 37, 5, 14, 22, 2};
    int phase_tx  [PHASES] = '{0, 74, 0, 8, 0, 74, 0, 8};
    int phase_rx  [PHASES] = '{0, 0, 74, 8, 0, 0, 74, 8};

    marker_frame_payload_extractor #(
        .MAX_PACKET_LEN(MAX_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    mfpe_checker #(
        .MAX_PACKET_LEN(MAX_LEN)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .words_owed   (words_owed)
    );

    always #10 clk = ~clk;

    // Receiver: stalls at random at the current rate, except during the one long hold-off,
    // when it refuses every word so that the result queue fills and the input is throttled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_go && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= (int'($urandom_range(99)) >= rx_stall_pct);
    end

    // Offers one byte, with random idle cycles first, and returns once it has been taken.
    // The valid stays high between back-to-back words.
    task automatic push_byte(input logic [7:0] b, input bit last);
        while (int'($urandom_range(99)) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends one packet of random content with the start marker at mark_at and the footer in
    // the last eight bytes, spoiled as the flaw asks. The footer wins where the two overlap.
    task automatic send_frame(input int len, input int mark_at, input flaw_e flaw);
        int         spoil;
        logic [7:0] b;
        logic [7:0] nz;
        spoil = len - 1 - int'($urandom_range(7));
        nz    = 8'($urandom_range(255, 1));
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(255));
            if (flaw != FLAW_NOISE)
            begin
                if (i == mark_at)
                    b = (flaw == FLAW_MARK1) ? (MARK_FIRST ^ nz) : MARK_FIRST;
                else if (i == mark_at + 1)
                    b = (flaw == FLAW_MARK2) ? (MARK_SECOND ^ nz) : MARK_SECOND;
                if (i == len - 8)
                    b = FOOT_FIRST;
                else if (i == len - 7)
                    b = FOOT_SECOND;
                else if (i > len - 7)
                    b = 8'h00;
                if (flaw == FLAW_FOOTER && i == spoil)
                    b = b ^ nz;
            end
            push_byte(b, i == len - 1);
        end
    endtask

    // Mostly well-formed frames with a short random payload; the rest carry a broken marker
    // or footer, are plain noise, or are too short to pass the length test.
    task automatic random_frame(input int off);
        int    pick;
        int    len;
        flaw_e flaw;
        pick = $urandom_range(99);
        flaw = FLAW_NONE;
        len  = off + 11 + int'($urandom_range(24));
        if (pick < 6)
            flaw = FLAW_MARK1;
        else if (pick < 12)
            flaw = FLAW_MARK2;
        else if (pick < 18)
            flaw = FLAW_FOOTER;
        else if (pick < 24)
        begin
            flaw = FLAW_NOISE;
            len  = $urandom_range(off + 36, 1);
        end
        else if (pick < 30)
            len = $urandom_range(off + 10, 1);
        else if (pick < 34)
            len = off + 10;
        send_frame(len, off, flaw);
    endtask

    // Drops the valid and waits until every owed word has left the block, plus a margin
    // for bytes that cause no word but may still be working through it.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_offset(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= 11'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_off = value;
    endtask

    initial
    begin
        int phase_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the shortest frame that passes at the reset offset, with lead-in bytes
        // alternating between all zeros and all ones and a payload of all ones, then two
        // packets of a single byte, which can never pass.
        for (int i = 0; i < 14; i++)
            push_byte((i % 2 == 1) ? 8'hFF : 8'h00, 1'b0);
        push_byte(MARK_FIRST, 1'b0);
        push_byte(MARK_SECOND, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(FOOT_FIRST, 1'b0);
        push_byte(FOOT_SECOND, 1'b0);
        for (int i = 0; i < 6; i++)
            push_byte(8'h00, i == 5);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        settle_block();

        // Random phases at small offsets, each with the idling pattern set for it. The first runs
        // at the reset offset and includes the long receiver hold-off.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
                set_offset(phase_off[ph]);
            tx_idle_pct  = phase_tx[ph];
            rx_stall_pct = phase_rx[ph];
            if (ph == 0)
                hold_go <= 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame(cur_off);
            settle_block();
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;

        // Large offset: a short packet never reaches the marker.
        set_offset(1500);
        send_frame(20, 1500, FLAW_NONE);
        settle_block();

        // Top of the offset range: short packets never reach the marker.
        set_offset(2047);
        send_frame(5, 2047, FLAW_NONE);
        send_frame(40, 2047, FLAW_NONE);
        settle_block();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
